/* hdl/fptd_pkg.sv */
// Shared types and constants for the fractal peak and trough detector.
package fptd_pkg;

  localparam int PRICE_W = 32;
  localparam int HALF_W  = 4;
  localparam int LIMIT_W = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // register indexes on the configuration port
  localparam logic REG_HALF_WINDOW = 1'b0;
  localparam logic REG_STORE_LIMIT = 1'b1;

  localparam logic [HALF_W-1:0]  HALF_WINDOW_RST = 4'd2;
  localparam logic [LIMIT_W-1:0] STORE_LIMIT_RST = 5'd16;

  typedef logic [PRICE_W-1:0] price_t;

  // per-cycle commands from the sequencer to one fractal store
  typedef struct packed {
    logic push;
    logic trim;
    logic rd_en;
  } fptd_store_cmd_t;

endpackage

/* hdl/fractal_peak_trough_detector.sv */
// Top level: sequencer, shared compare unit, configuration registers and result register.
//
// Usage: one bar (in_bar_high, in_bar_low) enters on the in_ channel when
// in_valid is high and in_stall is low. Each bar yields exactly one result
// word on the out_ channel, taken when out_valid is high and out_stall low.
// Work per bar, in order: the accepting cycle shifts the window, S_MID fetches
// the middle bar, S_SCAN compares it with the other window bars (only once the
// window is full), S_PUSH pushes found fractals, S_RSCAN scans the larger store
// for resistance and support, and S_DONE loads the result register. A new bar
// is taken only once the result register is loaded; in_stall stays high
// meanwhile. A finished result sits in the output register, so the next bar is
// taken while the receiver stalls; only a second result waits for the slot.
// Configuration goes through the APB-style port; the user must write it only
// while no bar is in flight, which the block does not enforce. Lowering
// store_limit trims both stores at the write. Reset (rst_n low at a clock
// edge) empties the window and both stores and restores half_window = 2 and
// store_limit = 16.
module fractal_peak_trough_detector #(
  parameter int MAX_HALF_WINDOW = 8,
  parameter int STORE_DEPTH     = 16,
  localparam int SCW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_bar_high,
  input  logic [31:0]                   in_bar_low,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_window_full,
  output logic                          out_high_found,
  output logic [31:0]                   out_high_value,
  output logic                          out_low_found,
  output logic [31:0]                   out_low_value,
  output logic [SCW-1:0]                out_high_count,
  output logic [SCW-1:0]                out_low_count,
  output logic [31:0]                   out_resistance,
  output logic                          out_resistance_valid,
  output logic [31:0]                   out_support,
  output logic                          out_support_valid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fptd_pkg::APB_AW-1:0]   paddr,
  input  logic [fptd_pkg::APB_DW-1:0]   pwdata,
  output logic [fptd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import fptd_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int WIDX      = $clog2(WIN_DEPTH);
  localparam int SAW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MID, S_SCAN, S_PUSH, S_RSCAN, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [HALF_W-1:0]   half_window_r, half_window_nxt;
  logic [LIMIT_W-1:0]  store_limit_r, store_limit_nxt;
  logic [WIDX-1:0]     k_r, k_nxt;
  price_t              mh_r, mh_nxt;
  price_t              ml_r, ml_nxt;
  logic                hf_r, hf_nxt;
  logic                lf_r, lf_nxt;
  logic                full_r, full_nxt;
  logic [SCW-1:0]      j_r, j_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SCW-1:0]      rd_j_r, rd_j_nxt;
  price_t              res_r, res_nxt;
  price_t              sup_r, sup_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                o_full_r, o_full_nxt;
  logic                o_hf_r, o_hf_nxt;
  price_t              o_hv_r, o_hv_nxt;
  logic                o_lf_r, o_lf_nxt;
  price_t              o_lv_r, o_lv_nxt;
  logic [SCW-1:0]      o_hc_r, o_hc_nxt;
  logic [SCW-1:0]      o_lc_r, o_lc_nxt;
  price_t              o_res_r, o_res_nxt;
  price_t              o_sup_r, o_sup_nxt;

  logic                accept;
  logic                cfg_wr;
  logic [WIDX-1:0]     eff_h;
  logic [WIDX-1:0]     span;
  logic [SCW-1:0]      eff_lim;
  logic [SCW-1:0]      new_lim;
  logic [WIDX-1:0]     win_idx;
  logic [WIDX-1:0]     fill;
  price_t              win_high, win_low;
  fptd_store_cmd_t     hcmd, lcmd;
  logic [SCW-1:0]      hcount, lcount;
  price_t              hdata, ldata;
  logic [SCW-1:0]      scan_n;
  logic                rd_en;

  function automatic logic [WIDX-1:0] clamp_half(input logic [HALF_W-1:0] v);
    logic [WIDX-1:0] r;
    if (v == '0) begin
      r = WIDX'(1);
    end else if (32'(v) > 32'(MAX_HALF_WINDOW)) begin
      r = WIDX'(MAX_HALF_WINDOW);
    end else begin
      r = WIDX'(v);
    end
    return r;
  endfunction

  function automatic logic [SCW-1:0] clamp_lim(input logic [LIMIT_W-1:0] v);
    logic [SCW-1:0] r;
    if (v == '0) begin
      r = SCW'(1);
    end else if (32'(v) > 32'(STORE_DEPTH)) begin
      r = SCW'(STORE_DEPTH);
    end else begin
      r = SCW'(v);
    end
    return r;
  endfunction

  assign accept  = in_valid && !in_stall;
  assign cfg_wr  = psel && penable && pwrite;
  assign eff_h   = clamp_half(half_window_r);
  assign span    = WIDX'({eff_h, 1'b1});
  assign eff_lim = clamp_lim(store_limit_r);
  assign new_lim = clamp_lim(pwdata[LIMIT_W-1:0]);
  assign win_idx = (state_r == S_MID) ? eff_h : k_r;
  assign scan_n  = (hcount > lcount) ? hcount : lcount;
  assign rd_en   = (state_r == S_RSCAN) && (j_r < scan_n);

  fptd_window #(
    .WIN_DEPTH (WIN_DEPTH),
    .IDX_W     (WIDX)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (accept),
    .din_high (in_bar_high),
    .din_low  (in_bar_low),
    .rd_idx   (win_idx),
    .rd_high  (win_high),
    .rd_low   (win_low),
    .fill     (fill)
  );

  always_comb begin
    hcmd.push  = (state_r == S_PUSH) && hf_r;
    hcmd.trim  = cfg_wr && (paddr[2] == REG_STORE_LIMIT);
    hcmd.rd_en = rd_en;
    lcmd.push  = (state_r == S_PUSH) && lf_r;
    lcmd.trim  = hcmd.trim;
    lcmd.rd_en = rd_en;
  end

  fptd_store #(
    .DEPTH (STORE_DEPTH),
    .CW    (SCW),
    .AW    (SAW)
  ) u_high_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (hcmd),
    .push_data (mh_r),
    .lim       (eff_lim),
    .trim_lim  (new_lim),
    .rd_idx    (j_r[SAW-1:0]),
    .rd_data   (hdata),
    .count     (hcount)
  );

  fptd_store #(
    .DEPTH (STORE_DEPTH),
    .CW    (SCW),
    .AW    (SAW)
  ) u_low_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (lcmd),
    .push_data (ml_r),
    .lim       (eff_lim),
    .trim_lim  (new_lim),
    .rd_idx    (j_r[SAW-1:0]),
    .rd_data   (ldata),
    .count     (lcount)
  );

  always_comb begin
    state_nxt       = state_r;
    half_window_nxt = half_window_r;
    store_limit_nxt = store_limit_r;
    k_nxt           = k_r;
    mh_nxt          = mh_r;
    ml_nxt          = ml_r;
    hf_nxt          = hf_r;
    lf_nxt          = lf_r;
    full_nxt        = full_r;
    j_nxt           = j_r;
    rd_vld_nxt      = 1'b0;
    rd_j_nxt        = j_r;
    res_nxt         = res_r;
    sup_nxt         = sup_r;
    out_valid_nxt   = out_valid_r && out_stall;
    o_full_nxt      = o_full_r;
    o_hf_nxt        = o_hf_r;
    o_hv_nxt        = o_hv_r;
    o_lf_nxt        = o_lf_r;
    o_lv_nxt        = o_lv_r;
    o_hc_nxt        = o_hc_r;
    o_lc_nxt        = o_lc_r;
    o_res_nxt       = o_res_r;
    o_sup_nxt       = o_sup_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_HALF_WINDOW) begin
        half_window_nxt = pwdata[HALF_W-1:0];
      end else begin
        store_limit_nxt = pwdata[LIMIT_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        full_nxt = (fill >= span);
        hf_nxt   = (fill >= span);
        lf_nxt   = (fill >= span);
        mh_nxt   = win_high;
        ml_nxt   = win_low;
        k_nxt    = '0;
        state_nxt = (fill >= span) ? S_SCAN : S_PUSH;
      end
      S_SCAN: begin
        // strict tests: any tie with the middle bar kills the fractal
        if (k_r != eff_h) begin
          if (win_high >= mh_r) hf_nxt = 1'b0;
          if (win_low <= ml_r)  lf_nxt = 1'b0;
        end
        k_nxt = k_r + WIDX'(1);
        if (k_r == span - WIDX'(1)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        j_nxt     = '0;
        res_nxt   = '0;
        sup_nxt   = '0;
        state_nxt = S_RSCAN;
      end
      S_RSCAN: begin
        // read issued for entry j, data for entry rd_j arrives in the next cycle
        rd_vld_nxt = rd_en;
        rd_j_nxt   = j_r;
        if (rd_en) begin
          j_nxt = j_r + SCW'(1);
        end
        if (rd_vld_r) begin
          if ((rd_j_r < hcount) && ((rd_j_r == '0) || (hdata > res_r))) begin
            res_nxt = hdata;
          end
          if ((rd_j_r < lcount) && ((rd_j_r == '0) || (ldata < sup_r))) begin
            sup_nxt = ldata;
          end
        end
        if (!rd_en && !rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_full_nxt    = full_r;
          o_hf_nxt      = hf_r;
          o_hv_nxt      = hf_r ? mh_r : '0;
          o_lf_nxt      = lf_r;
          o_lv_nxt      = lf_r ? ml_r : '0;
          o_hc_nxt      = hcount;
          o_lc_nxt      = lcount;
          o_res_nxt     = res_r;
          o_sup_nxt     = sup_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      half_window_r <= HALF_WINDOW_RST;
      store_limit_r <= STORE_LIMIT_RST;
      out_valid_r   <= 1'b0;
      rd_vld_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      half_window_r <= half_window_nxt;
      store_limit_r <= store_limit_nxt;
      out_valid_r   <= out_valid_nxt;
      rd_vld_r      <= rd_vld_nxt;
    end
    k_r      <= k_nxt;
    mh_r     <= mh_nxt;
    ml_r     <= ml_nxt;
    hf_r     <= hf_nxt;
    lf_r     <= lf_nxt;
    full_r   <= full_nxt;
    j_r      <= j_nxt;
    rd_j_r   <= rd_j_nxt;
    res_r    <= res_nxt;
    sup_r    <= sup_nxt;
    o_full_r <= o_full_nxt;
    o_hf_r   <= o_hf_nxt;
    o_hv_r   <= o_hv_nxt;
    o_lf_r   <= o_lf_nxt;
    o_lv_r   <= o_lv_nxt;
    o_hc_r   <= o_hc_nxt;
    o_lc_r   <= o_lc_nxt;
    o_res_r  <= o_res_nxt;
    o_sup_r  <= o_sup_nxt;
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HALF_WINDOW) begin
      prdata[HALF_W-1:0] = half_window_r;
    end else begin
      prdata[LIMIT_W-1:0] = store_limit_r;
    end
  end

  assign pready               = 1'b1;
  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_window_full      = o_full_r;
  assign out_high_found       = o_hf_r;
  assign out_high_value       = o_hv_r;
  assign out_low_found        = o_lf_r;
  assign out_low_value        = o_lv_r;
  assign out_high_count       = o_hc_r;
  assign out_low_count        = o_lc_r;
  assign out_resistance       = o_res_r;
  assign out_resistance_valid = (o_hc_r != '0);
  assign out_support          = o_sup_r;
  assign out_support_valid    = (o_lc_r != '0);

`ifndef SYNTH
  a_accept_to_mid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MID))
    else $error("accepted word did not start the sequence");

  a_scan_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r < span))
    else $error("window scan index past the span");

  a_found_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_high_found || out_low_found)) |-> out_window_full)
    else $error("fractal reported without a full window");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PUSH) && hf_r) |=> (hcount != '0))
    else $error("high store empty after a push");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (hcount <= eff_lim) && (lcount <= eff_lim))
    else $error("store count above the limit");
`endif

endmodule

/* hdl/fptd_window.sv */
// Shift line of the last bars (highs and lows) with one indexed read port.
module fptd_window #(
  parameter int WIN_DEPTH = 17,
  parameter int IDX_W     = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  fptd_pkg::price_t     din_high,
  input  fptd_pkg::price_t     din_low,
  input  logic [IDX_W-1:0]     rd_idx,
  output fptd_pkg::price_t     rd_high,
  output fptd_pkg::price_t     rd_low,
  output logic [IDX_W-1:0]     fill
);
  import fptd_pkg::*;

  price_t           high_r [WIN_DEPTH];
  price_t           low_r  [WIN_DEPTH];
  logic [IDX_W-1:0] fill_r;

  // tap 0 is the newest bar
  always_ff @(posedge clk) begin
    if (shift_en) begin
      high_r[0] <= din_high;
      low_r[0]  <= din_low;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        high_r[i] <= high_r[i-1];
        low_r[i]  <= low_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (shift_en && (fill_r != IDX_W'(WIN_DEPTH))) begin
      fill_r <= fill_r + IDX_W'(1);
    end
  end

  always_comb begin
    rd_high = '0;
    rd_low  = '0;
    if (32'(rd_idx) < 32'(WIN_DEPTH)) begin
      rd_high = high_r[rd_idx];
      rd_low  = low_r[rd_idx];
    end
  end

  assign fill = fill_r;

endmodule

/* hdl/fptd_store.sv */
// Ring buffer of fractal prices, oldest first, with trim, push and a registered scan read.
module fptd_store #(
  parameter int DEPTH = 16,
  parameter int CW    = 5,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fptd_pkg::fptd_store_cmd_t cmd,
  input  fptd_pkg::price_t        push_data,
  input  logic [CW-1:0]           lim,
  input  logic [CW-1:0]           trim_lim,
  input  logic [AW-1:0]           rd_idx,
  output fptd_pkg::price_t        rd_data,
  output logic [CW-1:0]           count
);
  import fptd_pkg::*;

  price_t        mem [DEPTH];
  price_t        rd_data_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_trim;

  // sum is below twice the depth, so one conditional subtract wraps it
  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= (CW+1)'(DEPTH)) ? s - (CW+1)'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  assign wr_addr   = wrap((CW+1)'(head_r) + (CW+1)'(count_r));
  assign rd_addr   = wrap((CW+1)'(head_r) + (CW+1)'(rd_idx));
  assign head_inc  = wrap((CW+1)'(head_r) + (CW+1)'(1));
  assign head_trim = wrap((CW+1)'(head_r) + (CW+1)'(count_r - trim_lim));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.trim) begin
      if (count_r > trim_lim) begin
        head_r  <= head_trim;
        count_r <= trim_lim;
      end
    end else if (cmd.push) begin
      if (count_r >= lim) begin
        head_r <= head_inc;   // full: the new word displaces the oldest
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule
